[src/tmi_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmi_pkg
// Shared widths, case codes, register indexes and pipeline stage types for
// the tissue mixture intensity core.
// ----------------------------------------------------------------------------
package tmi_pkg;

    localparam int PROB_W     = 15;
    localparam int MEAN_W     = 15;
    localparam int MASK_W     = 17;
    localparam int SUM_W      = 17;
    localparam int PROD_W     = PROB_W + MEAN_W;
    localparam int NUM_W      = PROD_W + 2;
    localparam int DEN_W      = SUM_W;
    localparam int DIVN_W     = NUM_W + 2;
    localparam int DIVD_W     = DEN_W + 1;
    localparam int QUO_W      = 15;
    localparam int CASE_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_MEAN_A       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEAN_B       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MEAN_C       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_TOL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_TOTAL   = 3'd4;

    localparam logic [MEAN_W-1:0] MEAN_RESET = 15'd0;
    localparam logic [PROB_W-1:0] TOL_RESET  = 15'd1;
    localparam logic [MASK_W-1:0] MASK_RESET = 17'd255;

    typedef enum logic [CASE_W-1:0] {
        MIX_MASKED = 3'd0,
        MIX_A      = 3'd1,
        MIX_B      = 3'd2,
        MIX_AB     = 3'd3,
        MIX_C      = 3'd4,
        MIX_BC     = 3'd5,
        MIX_AC     = 3'd6,
        MIX_ABC    = 3'd7
    } mix_case_t;

    typedef struct packed {
        logic [MEAN_W-1:0] mean_a;
        logic [MEAN_W-1:0] mean_b;
        logic [MEAN_W-1:0] mean_c;
        logic [PROB_W-1:0] presence_tol;
        logic [MASK_W-1:0] mask_total;
    } cfg_t;

    typedef struct packed {
        logic [PROB_W-1:0] w_a;
        logic [PROB_W-1:0] w_b;
        logic [PROB_W-1:0] w_c;
        mix_case_t         code;
    } cls_t;

    typedef struct packed {
        logic [PROD_W-1:0] p_a;
        logic [PROD_W-1:0] p_b;
        logic [PROD_W-1:0] p_c;
        logic [DEN_W-1:0]  den;
        mix_case_t         code;
    } prod_t;

    typedef struct packed {
        logic [DIVN_W-1:0] rem;
        logic [DIVD_W-1:0] dvs;
        logic [QUO_W-1:0]  quo;
        logic              zero;
        mix_case_t         code;
    } div_t;

endpackage
`default_nettype wire

[src/tissue_mixture_intensity_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tissue_mixture_intensity_core
// Maps one voxel of three tissue probabilities to a simulated intensity and
// its mixture case code.
//
// The input channel carries one voxel request (prob_a, prob_b, prob_c) under
// in_valid / in_stall; the output channel carries intensity and mix_case
// under out_valid / out_stall. A request moves when valid is high and stall
// is low. Class means, the presence tolerance and the mask total are written
// through cfg_we / cfg_index / cfg_data. The user must write them only while
// no voxel is in flight; the core itself does not enforce this.
//
// An accepted request passes one classify stage, two multiply and sum stages
// and a 15-stage divider that resolves one quotient bit per stage; its result
// then shows on out_valid. One voxel is accepted every cycle while in_stall
// is low. Each divider stage holds a single compare and subtract.
//
// Reset clears all stage valid bits and loads the register defaults. When
// the receiver stalls, the output holds steady and each stage keeps its
// request until the stage after it frees; in_stall rises only once every
// stage is occupied.
// ----------------------------------------------------------------------------
module tissue_mixture_intensity_core
    import tmi_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [PROB_W-1:0]     prob_a,
    input  wire logic [PROB_W-1:0]     prob_b,
    input  wire logic [PROB_W-1:0]     prob_c,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [QUO_W-1:0]           intensity,
    output logic [CASE_W-1:0]          mix_case
);

    cfg_t cfg_reg;
    logic in_ready;
    logic cls_valid;
    logic cls_ready;
    cls_t cls_data;
    logic mac_valid;
    logic mac_ready;
    div_t mac_data;
    div_t div_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mean_a       <= MEAN_RESET;
            cfg_reg.mean_b       <= MEAN_RESET;
            cfg_reg.mean_c       <= MEAN_RESET;
            cfg_reg.presence_tol <= TOL_RESET;
            cfg_reg.mask_total   <= MASK_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MEAN_A:       cfg_reg.mean_a       <= cfg_data[MEAN_W-1:0];
                REG_MEAN_B:       cfg_reg.mean_b       <= cfg_data[MEAN_W-1:0];
                REG_MEAN_C:       cfg_reg.mean_c       <= cfg_data[MEAN_W-1:0];
                REG_PRESENCE_TOL: cfg_reg.presence_tol <= cfg_data[PROB_W-1:0];
                REG_MASK_TOTAL:   cfg_reg.mask_total   <= cfg_data[MASK_W-1:0];
                default:          ;
            endcase
        end
    end

    tmi_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .prob_a    (prob_a),
        .prob_b    (prob_b),
        .prob_c    (prob_c),
        .out_valid (cls_valid),
        .out_ready (cls_ready),
        .out_data  (cls_data)
    );

    tmi_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (cls_valid),
        .in_ready  (cls_ready),
        .in_data   (cls_data),
        .out_valid (mac_valid),
        .out_ready (mac_ready),
        .out_data  (mac_data)
    );

    tmi_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mac_valid),
        .in_ready  (mac_ready),
        .in_data   (mac_data),
        .out_valid (out_valid),
        .out_ready (!out_stall),
        .out_data  (div_data)
    );

    assign in_stall  = !in_ready;
    assign intensity = div_data.quo;
    assign mix_case  = div_data.code;

endmodule
`default_nettype wire

[src/tmi_classify.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmi_classify
// First pipeline stage: mask test, class presence and case selection. Emits
// the weights of the weighted average. A pure case gets a weight of one on
// its class, a masked voxel gets all-zero weights.
// ----------------------------------------------------------------------------
module tmi_classify
    import tmi_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfg_t              cfg,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [PROB_W-1:0] prob_a,
    input  wire logic [PROB_W-1:0] prob_b,
    input  wire logic [PROB_W-1:0] prob_c,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output cls_t                   out_data
);

    logic             valid_reg;
    cls_t             data_reg;
    cls_t             data_next;
    logic [SUM_W-1:0] sum;
    logic             masked;
    logic             has_a;
    logic             has_b;
    logic             has_c;
    logic [PROB_W-1:0] one;

    assign one = PROB_W'(1);
    assign sum = SUM_W'(prob_a) + SUM_W'(prob_b) + SUM_W'(prob_c);
    assign masked = sum < cfg.mask_total;
    assign has_a = prob_a >= cfg.presence_tol;
    assign has_b = prob_b >= cfg.presence_tol;
    assign has_c = prob_c >= cfg.presence_tol;

    always_comb
    begin
        data_next = '{w_a: '0, w_b: '0, w_c: '0, code: MIX_MASKED};
        if (!masked)
        begin
            if (!has_c)
            begin
                if (!has_b)
                begin
                    data_next.code = MIX_A;
                    data_next.w_a  = one;
                end
                else if (!has_a)
                begin
                    data_next.code = MIX_B;
                    data_next.w_b  = one;
                end
                else
                begin
                    data_next.code = MIX_AB;
                    data_next.w_a  = prob_a;
                    data_next.w_b  = prob_b;
                end
            end
            else if (!has_a)
            begin
                if (!has_b)
                begin
                    data_next.code = MIX_C;
                    data_next.w_c  = one;
                end
                else
                begin
                    data_next.code = MIX_BC;
                    data_next.w_b  = prob_b;
                    data_next.w_c  = prob_c;
                end
            end
            else if (!has_b)
            begin
                data_next.code = MIX_AC;
                data_next.w_a  = prob_a;
                data_next.w_c  = prob_c;
            end
            else
            begin
                data_next.code = MIX_ABC;
                data_next.w_a  = prob_a;
                data_next.w_b  = prob_b;
                data_next.w_c  = prob_c;
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

[src/tmi_mac.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmi_mac
// Two pipeline stages: the three weight-times-mean products with the weight
// sum, then the rounded dividend 2*num+den and the divisor 2*den.
// ----------------------------------------------------------------------------
module tmi_mac
    import tmi_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire cls_t in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output div_t      out_data
);

    logic             prod_valid_reg;
    prod_t            prod_reg;
    prod_t            prod_next;
    logic             prod_ready;
    logic             div_valid_reg;
    div_t             div_reg;
    div_t             div_next;
    logic [NUM_W-1:0] num;

    always_comb
    begin
        prod_next.p_a  = in_data.w_a * cfg.mean_a;
        prod_next.p_b  = in_data.w_b * cfg.mean_b;
        prod_next.p_c  = in_data.w_c * cfg.mean_c;
        prod_next.den  = DEN_W'(in_data.w_a) + DEN_W'(in_data.w_b) + DEN_W'(in_data.w_c);
        prod_next.code = in_data.code;
    end

    assign num = NUM_W'(prod_reg.p_a) + NUM_W'(prod_reg.p_b) + NUM_W'(prod_reg.p_c);

    always_comb
    begin
        div_next.rem  = {num, 1'b0} + DIVN_W'(prod_reg.den);
        div_next.dvs  = {prod_reg.den, 1'b0};
        div_next.quo  = '0;
        div_next.zero = prod_reg.den == '0;
        div_next.code = prod_reg.code;
    end

    assign prod_ready = !div_valid_reg || out_ready;
    assign in_ready   = !prod_valid_reg || prod_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            div_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                prod_valid_reg <= in_valid;
            end
            if (prod_ready)
            begin
                div_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            prod_reg <= prod_next;
        end
        if (prod_ready && prod_valid_reg)
        begin
            div_reg <= div_next;
        end
    end

    assign out_valid = div_valid_reg;
    assign out_data  = div_reg;

endmodule
`default_nettype wire

[src/tmi_divider.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmi_divider
// Pipelined restoring divider, one quotient bit per stage, most significant
// bit first. A zero divisor leaves the quotient at zero.
// ----------------------------------------------------------------------------
module tmi_divider
    import tmi_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire div_t in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output div_t      out_data
);

    div_t src   [QUO_W+1];
    logic vld   [QUO_W+1];
    logic rdy   [QUO_W+1];

    assign src[0]     = in_data;
    assign vld[0]     = in_valid;
    assign rdy[QUO_W] = out_ready;
    assign in_ready   = rdy[0];

    genvar k;
    generate
        for (k = 0; k < QUO_W; k++)
        begin : g_stage
            localparam int BIT = QUO_W - 1 - k;

            logic              valid_reg;
            div_t              data_reg;
            div_t              data_next;
            logic [DIVN_W-1:0] trial;
            logic              take;

            assign trial = DIVN_W'(src[k].dvs) << BIT;
            assign take  = !src[k].zero && (src[k].rem >= trial);

            always_comb
            begin
                data_next          = src[k];
                data_next.quo[BIT] = take;
                if (take)
                begin
                    data_next.rem = src[k].rem - trial;
                end
            end

            assign rdy[k] = !valid_reg || rdy[k+1];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg <= 1'b0;
                end
                else if (rdy[k])
                begin
                    valid_reg <= vld[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (rdy[k] && vld[k])
                begin
                    data_reg <= data_next;
                end
            end

            assign src[k+1] = data_reg;
            assign vld[k+1] = valid_reg;
        end
    endgenerate

    assign out_valid = vld[QUO_W];
    assign out_data  = src[QUO_W];

endmodule
`default_nettype wire

[src/tmi_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmi_checker
// Port-level checks for the tissue mixture intensity core, bound to the top
// level.
// ----------------------------------------------------------------------------
module tmi_checker
    import tmi_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_stall,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire logic [QUO_W-1:0]  intensity,
    input wire logic [CASE_W-1:0] mix_case
);

    // The pipeline is empty and open while reset is held.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> (!out_valid && !in_stall))
        else $error("pipeline not empty during reset");

    // A free output slot lets every stage move, so the input cannot stall.
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || !out_stall) |-> !in_stall)
        else $error("input stalled while output slot is free");

    // A masked voxel always yields zero intensity.
    a_masked_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && mix_case == MIX_MASKED) |-> intensity == '0)
        else $error("masked voxel with nonzero intensity");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("output request dropped under stall");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(intensity) && $stable(mix_case)))
        else $error("output payload changed under stall");

endmodule

bind tissue_mixture_intensity_core tmi_checker u_tmi_checker (.*);
`default_nettype wire

[test/tb_tissue_mixture_intensity_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tissue_mixture_intensity_core
// Self-checking bench for the tissue mixture intensity core. Voxel requests
// are driven under random sender gaps and receiver stalls. A local predictor
// computes the intensity and case code for each accepted voxel. The checker
// compares every result, in order, against the oldest prediction. Directed
// tests cover the reset state, every mixture case, the rounding, the mask
// and tolerance edges, and register data wider than its register. Random
// traffic then runs under several register settings. One test holds off the
// receiver long enough to fill the pipeline.
// ----------------------------------------------------------------------------
module tb_tissue_mixture_intensity_core;
    import tmi_pkg::*;

    localparam int PIPE_LATENCY = 18;
    localparam int HOLD_CYCLES  = 80;
    localparam int PROB_MAX     = 32767;
    localparam int SUM_MAX      = 98301;

    typedef struct packed {
        logic [QUO_W-1:0] intensity;
        mix_case_t        code;
    } voxel_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [PROB_W-1:0]     prob_a;
    logic [PROB_W-1:0]     prob_b;
    logic [PROB_W-1:0]     prob_c;
    logic                  out_valid;
    logic                  out_stall;
    logic [QUO_W-1:0]      intensity;
    logic [CASE_W-1:0]     mix_case;

    cfg_t          model_cfg;
    voxel_result_t expected_voxels[$];
    int            mismatch_count = 0;
    int            send_idle_pct;
    int            recv_idle_pct;
    int            hold_requests = 0;
    int            holds_served = 0;
    int            hold_left = 0;

    tissue_mixture_intensity_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .prob_a    (prob_a),
        .prob_b    (prob_b),
        .prob_c    (prob_c),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .intensity (intensity),
        .mix_case  (mix_case)
    );

    always #5 clk = ~clk;

    initial
    begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [QUO_W-1:0] rounded_mix(input logic [63:0] num,
                                                     input logic [63:0] den);
        logic [63:0] q;
        if (den == 64'd0)
            return '0;
        q = (2 * num + den) / (2 * den);
        if (q > 64'h7FFF)
            q = 64'h7FFF;
        return q[QUO_W-1:0];
    endfunction

    function automatic voxel_result_t predict_voxel(input logic [PROB_W-1:0] pa,
                                                    input logic [PROB_W-1:0] pb,
                                                    input logic [PROB_W-1:0] pc);
        logic [63:0]   wa, wb, wc, ma, mb, mc;
        logic          has_a, has_b, has_c;
        voxel_result_t r;
        wa = pa;
        wb = pb;
        wc = pc;
        ma = model_cfg.mean_a;
        mb = model_cfg.mean_b;
        mc = model_cfg.mean_c;
        if (wa + wb + wc < {47'd0, model_cfg.mask_total})
        begin
            r.intensity = '0;
            r.code      = MIX_MASKED;
            return r;
        end
        has_a = pa >= model_cfg.presence_tol;
        has_b = pb >= model_cfg.presence_tol;
        has_c = pc >= model_cfg.presence_tol;
        if (!has_c)
        begin
            if (!has_b)
            begin
                r.code      = MIX_A;
                r.intensity = model_cfg.mean_a;
            end
            else if (!has_a)
            begin
                r.code      = MIX_B;
                r.intensity = model_cfg.mean_b;
            end
            else
            begin
                r.code      = MIX_AB;
                r.intensity = rounded_mix(wa * ma + wb * mb, wa + wb);
            end
        end
        else if (!has_a)
        begin
            if (!has_b)
            begin
                r.code      = MIX_C;
                r.intensity = model_cfg.mean_c;
            end
            else
            begin
                r.code      = MIX_BC;
                r.intensity = rounded_mix(wb * mb + wc * mc, wb + wc);
            end
        end
        else if (!has_b)
        begin
            r.code      = MIX_AC;
            r.intensity = rounded_mix(wa * ma + wc * mc, wa + wc);
        end
        else
        begin
            r.code      = MIX_ABC;
            r.intensity = rounded_mix(wa * ma + wb * mb + wc * mc, wa + wb + wc);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    always @(posedge clk)
    begin
        voxel_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_voxels.size() == 0)
            begin
                report_mismatch($sformatf("result with no request pending: %0d case %0d",
                                          intensity, mix_case));
            end
            else
            begin
                want = expected_voxels.pop_front();
                if (intensity !== want.intensity)
                    report_mismatch($sformatf("intensity %0d, expected %0d",
                                              intensity, want.intensity));
                if (mix_case !== want.code)
                    report_mismatch($sformatf("mix_case %0d, expected %0d",
                                              mix_case, want.code));
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (holds_served != hold_requests)
        begin
            hold_left    <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end
    end

    always @(negedge clk)
        out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);

    task automatic send_voxel(input logic [PROB_W-1:0] pa,
                              input logic [PROB_W-1:0] pb,
                              input logic [PROB_W-1:0] pc);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        prob_a   <= pa;
        prob_b   <= pb;
        prob_c   <= pc;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_voxels.push_back(predict_voxel(pa, pb, pc));
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_voxels.size() != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY + 2) @(negedge clk);
    endtask

    task automatic apply_config(input logic [CFG_DATA_W-1:0] ma,
                                input logic [CFG_DATA_W-1:0] mb,
                                input logic [CFG_DATA_W-1:0] mc,
                                input logic [CFG_DATA_W-1:0] tol,
                                input logic [CFG_DATA_W-1:0] mask);
        logic [CFG_DATA_W-1:0] vals[5];
        logic [CFG_IDX_W-1:0]  idx[5];
        vals = '{ma, mb, mc, tol, mask};
        idx  = '{REG_MEAN_A, REG_MEAN_B, REG_MEAN_C, REG_PRESENCE_TOL, REG_MASK_TOTAL};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        model_cfg.mean_a       = ma[MEAN_W-1:0];
        model_cfg.mean_b       = mb[MEAN_W-1:0];
        model_cfg.mean_c       = mc[MEAN_W-1:0];
        model_cfg.presence_tol = tol[PROB_W-1:0];
        model_cfg.mask_total   = mask[MASK_W-1:0];
        @(negedge clk);
    endtask

    function automatic logic [PROB_W-1:0] random_prob(input logic [PROB_W-1:0] tol);
        case ($urandom_range(4))
            0: return (tol == 0) ? '0 : PROB_W'($urandom_range(tol - 1));
            1: return PROB_W'($urandom_range(PROB_MAX, tol));
            2: return (tol == 0) ? PROB_W'(PROB_MAX) : tol - 1'b1;
            3: return ($urandom_range(1) == 0) ? '0 : PROB_W'(PROB_MAX);
            default: return PROB_W'($urandom());
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_mean();
        case ($urandom_range(5))
            0: return '0;
            1: return CFG_DATA_W'(PROB_MAX);
            default: return CFG_DATA_W'($urandom());
        endcase
    endfunction

    task automatic random_config();
        logic [CFG_DATA_W-1:0] tol, mask;
        case ($urandom_range(5))
            0: tol = '0;
            1: tol = CFG_DATA_W'(1);
            2: tol = CFG_DATA_W'(PROB_MAX);
            3: tol = CFG_DATA_W'($urandom_range(PROB_MAX));
            default: tol = CFG_DATA_W'($urandom_range(2000, 1));
        endcase
        case ($urandom_range(5))
            0: mask = '0;
            1: mask = CFG_DATA_W'($urandom_range(2000));
            2: mask = ($urandom_range(1) == 0) ? CFG_DATA_W'(SUM_MAX) : '1;
            default: mask = CFG_DATA_W'($urandom_range(SUM_MAX));
        endcase
        apply_config(random_mean(), random_mean(), random_mean(), tol, mask);
    endtask

    task automatic test_reset_defaults();
        send_voxel(0, 0, 0);
        send_voxel(254, 0, 0);
        send_voxel(255, 0, 0);
        send_voxel(100, 100, 100);
        wait_idle();
    endtask

    task automatic test_case_tree();
        apply_config(1000, 20000, PROB_MAX, 100, 0);
        send_voxel(200, 0, 0);
        send_voxel(0, 200, 0);
        send_voxel(300, 500, 0);
        send_voxel(0, 0, 200);
        send_voxel(0, 400, 600);
        send_voxel(700, 0, 900);
        send_voxel(PROB_MAX, PROB_MAX, PROB_MAX);
        send_voxel(99, 99, 99);
        wait_idle();
    endtask

    task automatic test_rounding();
        apply_config(0, 1, 2, 1, 0);
        send_voxel(3, 1, 0);
        send_voxel(1, 1, 0);
        send_voxel(0, 1, 1);
        send_voxel(PROB_MAX, PROB_MAX, PROB_MAX);
        wait_idle();
    endtask

    task automatic test_mask_edges();
        apply_config(5, 6, 7, 1, SUM_MAX);
        send_voxel(PROB_MAX, PROB_MAX, PROB_MAX);
        send_voxel(PROB_MAX, PROB_MAX, PROB_MAX - 1);
        wait_idle();
        apply_config(5, 6, 7, 1, '1);
        send_voxel(PROB_MAX, PROB_MAX, PROB_MAX);
        wait_idle();
        apply_config(5, 6, 7, 1, 0);
        send_voxel(0, 0, 0);
        wait_idle();
    endtask

    task automatic test_zero_tolerance();
        apply_config(PROB_MAX, 1234, 0, 0, 0);
        send_voxel(0, 0, 0);
        send_voxel(0, 0, 5);
        send_voxel(PROB_MAX, 0, 0);
        wait_idle();
    endtask

    task automatic test_wide_config_data();
        apply_config(17'h1FFFF, 17'h18000, 17'h10001, 17'h1FFFF, 300);
        send_voxel(PROB_MAX, PROB_MAX, 100);
        wait_idle();
    endtask

    task automatic test_output_hold_off();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_config(4000, 12000, 30000, 500, 1000);
        hold_requests++;
        repeat (64)
            send_voxel(random_prob(model_cfg.presence_tol),
                       random_prob(model_cfg.presence_tol),
                       random_prob(model_cfg.presence_tol));
        wait_idle();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (4)
        begin
            random_config();
            repeat (100)
                send_voxel(random_prob(model_cfg.presence_tol),
                           random_prob(model_cfg.presence_tol),
                           random_prob(model_cfg.presence_tol));
            wait_idle();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        prob_a    = '0;
        prob_b    = '0;
        prob_c    = '0;
        out_stall = 1'b0;
        model_cfg.mean_a       = MEAN_RESET;
        model_cfg.mean_b       = MEAN_RESET;
        model_cfg.mean_c       = MEAN_RESET;
        model_cfg.presence_tol = TOL_RESET;
        model_cfg.mask_total   = MASK_RESET;
        send_idle_pct = 38;
        recv_idle_pct = 86;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_case_tree();
        test_rounding();
        test_mask_edges();
        test_zero_tolerance();
        test_wide_config_data();
        test_output_hold_off();
        test_random_traffic(38, 86);
        test_random_traffic(86, 38);
        test_random_traffic(0, 0);

        repeat (PIPE_LATENCY + 4) @(negedge clk);
        if (expected_voxels.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_voxels.size()));
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
src/tmi_pkg.sv
src/tmi_classify.sv
src/tmi_mac.sv
src/tmi_divider.sv
src/tissue_mixture_intensity_core.sv
src/tmi_checker.sv
test/tb_tissue_mixture_intensity_core.sv
